@@ rtl/core/qme_pkg.sv @@
// Shared types and constants for the queue machine execute unit.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package qme_pkg;

  localparam int unsigned WordW        = 16;
  localparam int unsigned OpW          = 5;
  localparam int unsigned RegAddrW     = 5;
  localparam int unsigned LabelW       = 12;
  localparam int unsigned RegCount     = 26;
  localparam int unsigned ProgramDepth = 4096;

  typedef enum logic [OpW-1:0] {
    OP_PUSH         = 5'd0,
    OP_ADD          = 5'd1,
    OP_SUB          = 5'd2,
    OP_MUL          = 5'd3,
    OP_DIV          = 5'd4,
    OP_MOD          = 5'd5,
    OP_POP_TO_REG   = 5'd6,
    OP_PUSH_REG     = 5'd7,
    OP_PRINT_POP    = 5'd8,
    OP_PRINT_REG    = 5'd9,
    OP_CHAR_POP     = 5'd10,
    OP_CHAR_REG     = 5'd11,
    OP_JUMP         = 5'd12,
    OP_JUMP_ZERO    = 5'd13,
    OP_JUMP_EQUAL   = 5'd14,
    OP_JUMP_GREATER = 5'd15,
    OP_QUIT         = 5'd16,
    OP_NOP          = 5'd17
  } op_e;

  typedef enum logic [1:0] {
    EMIT_NONE   = 2'd0,
    EMIT_NUMBER = 2'd1,
    EMIT_CHAR   = 2'd2
  } emit_e;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_UNDERFLOW = 2'd1,
    FAULT_OVERFLOW  = 2'd2
  } fault_e;

  // Value queue commands from the sequencer.
  typedef struct packed {
    logic rd;    // read the front entry, data valid next cycle
    logic pop;   // advance the head
    logic push;  // write at the tail and advance it
  } qme_q_ctl_t;

  // Value queue occupancy seen by the sequencer.
  typedef struct packed {
    logic full;
    logic has_one;
    logic has_two;
  } qme_q_status_t;

endpackage

@@ rtl/core/queue_machine_executor_unit.sv @@
// Queue machine execute unit: one request at a time, result held in an output register.
// Register, jump and single-pop ops pass through the read, execute and output states;
// add/sub/mul add a second read, execute and write-back; div/mod also wait on the
// 16-step divider. A new request is taken while the previous result waits, in the cycle
// after the result loads; the output state holds while the output register stalls.
// Reset clears pointers, register valid bits and the halt flag at once; no clearing pass.
`timescale 1ns / 1ps

module queue_machine_executor_unit import qme_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OpW-1:0]      op_i,
  input  logic [RegAddrW-1:0] first_reg_i,
  input  logic [RegAddrW-1:0] second_reg_i,
  input  logic [WordW-1:0]    literal_i,
  input  logic [LabelW-1:0]   label_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          emit_kind_o,
  output logic [WordW-1:0]    emit_value_o,
  output logic                redirect_o,
  output logic [LabelW-1:0]   redirect_target_o,
  output logic                halted_o,
  output logic [1:0]          fault_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_EX   = 8'b0000_0100,
    S_RDB  = 8'b0000_1000,
    S_EXB  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_WB   = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // latched request
  op_e                 op_q;
  logic [RegAddrW-1:0] r1_q, r2_q;
  logic [WordW-1:0]    lit_q;
  logic [LabelW-1:0]   label_q;

  // result under construction
  emit_e             kind_q, kind_d;
  logic [WordW-1:0]  val_q, val_d;
  logic              redir_q, redir_d;
  logic              halt_q, halt_d;
  fault_e            fault_q, fault_d;
  logic              stopped_q, stopped_d;
  logic [WordW-1:0]  a_q, a_d;
  logic [WordW-1:0]  res_q, res_d;

  // output register
  logic              out_valid_q;
  logic [1:0]        out_kind_q;
  logic [WordW-1:0]  out_val_q;
  logic              out_redir_q;
  logic [LabelW-1:0] out_target_q;
  logic              out_halt_q;
  logic [1:0]        out_fault_q;
  logic              out_load;

  qme_q_ctl_t        q_ctl;
  qme_q_status_t     q_status;
  logic [WordW-1:0]  q_wdata, q_rdata;

  logic              rf_rd, rf_we;
  logic [WordW-1:0]  rf_wdata, ra, rb;

  logic              div_start, div_done;
  logic [WordW-1:0]  div_quo, div_rem;
  logic [2*WordW-1:0] prod;
  logic [LabelW-1:0] target;
  logic              accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign prod       = a_q * q_rdata;
  // label_index never reaches the program depth, so the wrap is a plain mask
  assign target     = LabelW'(label_q % ProgramDepth);

  qme_value_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (q_ctl),
    .wdata_i  (q_wdata),
    .rdata_o  (q_rdata),
    .status_o (q_status)
  );

  qme_reg_file u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rf_rd),
    .raddr_a_i (r1_q),
    .raddr_b_i (r2_q),
    .rdata_a_o (ra),
    .rdata_b_o (rb),
    .we_i      (rf_we),
    .waddr_i   (r1_q),
    .wdata_i   (rf_wdata)
  );

  qme_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (a_q),
    .divisor_i   (q_rdata),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    val_d     = val_q;
    redir_d   = redir_q;
    halt_d    = halt_q;
    fault_d   = fault_q;
    stopped_d = stopped_q;
    a_d       = a_q;
    res_d     = res_q;
    q_ctl     = '0;
    q_wdata   = res_q;
    rf_rd     = 1'b0;
    rf_we     = 1'b0;
    rf_wdata  = q_rdata;
    div_start = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        rf_rd    = 1'b1;
        q_ctl.rd = 1'b1;
        kind_d   = EMIT_NONE;
        val_d    = '0;
        redir_d  = 1'b0;
        halt_d   = 1'b0;
        fault_d  = FAULT_NONE;
        state_d  = S_EX;
      end
      S_EX: begin
        state_d = S_OUT;
        if (stopped_q) begin
          halt_d = 1'b1;
        end else begin
          case (op_q)
            OP_PUSH, OP_PUSH_REG: begin
              if (q_status.full) begin
                fault_d = FAULT_OVERFLOW;
              end else begin
                q_ctl.push = 1'b1;
                q_wdata    = (op_q == OP_PUSH) ? lit_q : ra;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
              if (!q_status.has_two) begin
                fault_d = FAULT_UNDERFLOW;
              end else begin
                q_ctl.pop = 1'b1;
                a_d       = q_rdata;
                state_d   = S_RDB;
              end
            end
            OP_POP_TO_REG, OP_PRINT_POP, OP_CHAR_POP: begin
              if (!q_status.has_one) begin
                fault_d = FAULT_UNDERFLOW;
              end else begin
                q_ctl.pop = 1'b1;
                if (op_q == OP_POP_TO_REG) begin
                  rf_we = 1'b1;
                end else if (op_q == OP_PRINT_POP) begin
                  kind_d = EMIT_NUMBER;
                  val_d  = q_rdata;
                end else begin
                  kind_d = EMIT_CHAR;
                  val_d  = {8'h00, q_rdata[7:0]};
                end
              end
            end
            OP_PRINT_REG: begin
              kind_d = EMIT_NUMBER;
              val_d  = ra;
            end
            OP_CHAR_REG: begin
              kind_d = EMIT_CHAR;
              val_d  = {8'h00, ra[7:0]};
            end
            OP_JUMP:         redir_d = 1'b1;
            OP_JUMP_ZERO:    redir_d = (ra == '0);
            OP_JUMP_EQUAL:   redir_d = (ra == rb);
            OP_JUMP_GREATER: redir_d = (ra > rb);
            OP_QUIT: begin
              stopped_d = 1'b1;
              halt_d    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_RDB: begin
        q_ctl.rd = 1'b1;
        state_d  = S_EXB;
      end
      S_EXB: begin
        q_ctl.pop = 1'b1;
        state_d   = S_WB;
        case (op_q)
          OP_ADD: res_d = a_q + q_rdata;
          OP_SUB: res_d = a_q - q_rdata;
          OP_MUL: res_d = prod[WordW-1:0];
          default: begin
            // divide or modulo by zero pushes zero
            if (q_rdata == '0) begin
              res_d = '0;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = (op_q == OP_DIV) ? div_quo : div_rem;
          state_d = S_WB;
        end
      end
      S_WB: begin
        q_ctl.push = 1'b1;
        q_wdata    = res_q;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(op_i);
      r1_q    <= first_reg_i;
      r2_q    <= second_reg_i;
      lit_q   <= literal_i;
      label_q <= label_index_i;
    end
    kind_q  <= kind_d;
    val_q   <= val_d;
    redir_q <= redir_d;
    halt_q  <= halt_d;
    fault_q <= fault_d;
    a_q     <= a_d;
    res_q   <= res_d;
    if (out_load) begin
      out_kind_q   <= kind_q;
      out_val_q    <= val_q;
      out_redir_q  <= redir_q;
      out_target_q <= redir_q ? target : '0;
      out_halt_q   <= halt_q;
      out_fault_q  <= fault_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      stopped_q <= stopped_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign emit_kind_o       = out_kind_q;
  assign emit_value_o      = out_val_q;
  assign redirect_o        = out_redir_q;
  assign redirect_target_o = out_target_q;
  assign halted_o          = out_halt_q;
  assign fault_o           = out_fault_q;

endmodule

@@ rtl/core/qme_value_queue.sv @@
// Value queue: one synchronous memory with head, tail and fill count.
// Depends on qme_pkg for the command and status structs.
`timescale 1ns / 1ps

module qme_value_queue import qme_pkg::*; #(
  parameter int unsigned Depth = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qme_q_ctl_t       ctl_i,
  input  logic [WordW-1:0] wdata_i,
  output logic [WordW-1:0] rdata_o,
  output qme_q_status_t    status_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [WordW-1:0] mem_q [Depth];
  logic [WordW-1:0] rdata_q;
  logic [PtrW-1:0]  head_q, head_d;
  logic [PtrW-1:0]  tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] nxt;
    if (ptr == PtrW'(Depth - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + PtrW'(1);
    end
    return nxt;
  endfunction

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[tail_q] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[head_q];
    end
  end

  always_comb begin
    head_d  = ctl_i.pop  ? next_ptr(head_q) : head_q;
    tail_d  = ctl_i.push ? next_ptr(tail_q) : tail_q;
    count_d = count_q;
    case ({ctl_i.push, ctl_i.pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign rdata_o          = rdata_q;
  assign status_o.full    = (count_q == CntW'(Depth));
  assign status_o.has_one = (count_q != '0);
  assign status_o.has_two = (count_q > CntW'(1));

endmodule

@@ rtl/core/qme_reg_file.sv @@
// Register file: synchronous memory, two read ports and one write port.
// Valid bits stand for the all-zero reset. Depends on qme_pkg.
`timescale 1ns / 1ps

module qme_reg_file import qme_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_i,
  input  logic [RegAddrW-1:0] raddr_a_i,
  input  logic [RegAddrW-1:0] raddr_b_i,
  output logic [WordW-1:0]    rdata_a_o,
  output logic [WordW-1:0]    rdata_b_o,
  input  logic                we_i,
  input  logic [RegAddrW-1:0] waddr_i,
  input  logic [WordW-1:0]    wdata_i
);

  logic [WordW-1:0]    mem_q [RegCount];
  logic [RegCount-1:0] valid_q;
  logic [WordW-1:0]    data_a_q, data_b_q;
  logic                hit_a_q, hit_b_q;
  logic                in_a, in_b, in_w;

  assign in_a = (raddr_a_i < RegAddrW'(RegCount));
  assign in_b = (raddr_b_i < RegAddrW'(RegCount));
  assign in_w = (waddr_i < RegAddrW'(RegCount));

  always_ff @(posedge clk_i) begin
    if (we_i && in_w) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (rd_i) begin
      data_a_q <= mem_q[raddr_a_i];
      data_b_q <= mem_q[raddr_b_i];
    end
  end

  // An entry never written, or an index past the file, reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      if (we_i && in_w) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (rd_i) begin
        hit_a_q <= in_a && valid_q[raddr_a_i];
        hit_b_q <= in_b && valid_q[raddr_b_i];
      end
    end
  end

  assign rdata_a_o = hit_a_q ? data_a_q : '0;
  assign rdata_b_o = hit_b_q ? data_b_q : '0;

endmodule

@@ rtl/core/qme_divider.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on qme_pkg for the word width.
`timescale 1ns / 1ps

module qme_divider import qme_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] dividend_i,
  input  logic [WordW-1:0] divisor_i,
  output logic             done_o,
  output logic [WordW-1:0] quotient_o,
  output logic [WordW-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(WordW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [WordW-1:0] quo_q, rem_q, dvs_q;
  logic [WordW:0]   trial;

  assign trial = {rem_q, quo_q[WordW-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      // keep the trial difference when it does not go negative
      if (!trial[WordW]) begin
        rem_q <= trial[WordW-1:0];
        quo_q <= {quo_q[WordW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[WordW-2:0], quo_q[WordW-1]};
        quo_q <= {quo_q[WordW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(WordW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
